[rtl/bma_pkg.sv]
package bma_pkg;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_TEST  = 2'd2;
  localparam logic [1:0] ACT_FIND  = 2'd3;

  localparam logic [8:0] CNT_RESET = 9'd256;
  localparam int unsigned INDEX_SPAN = 256;

  typedef struct packed {
    logic accept;
    logic eval;
    logic out_load;
  } bma_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } bma_status_t;

endpackage

[rtl/bma_ctrl.sv]
module bma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bma_pkg::bma_status_t status,
  output bma_pkg::bma_cmd_t    cmd
);
  import bma_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.eval     = 1'b0;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_EX;
      end
      S_EX: begin
        cmd.eval = 1'b1;
        if (status.scan_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/bma_dp.sv]
module bma_dp #(
  parameter int unsigned MAP_BITS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [8:0]           cfg_wr_data,
  input  logic [1:0]           action,
  input  logic [7:0]           bit_index,
  input  bma_pkg::bma_cmd_t    cmd,
  output bma_pkg::bma_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 bit_was_set,
  output logic                 found,
  output logic [7:0]           free_index
);
  import bma_pkg::*;

  localparam int unsigned MAP_BYTES = (MAP_BITS + 7) / 8;
  localparam int unsigned CAP_BITS  = (MAP_BITS < INDEX_SPAN) ? MAP_BITS : INDEX_SPAN;
  localparam int unsigned MAP_DEPTH = (CAP_BITS + 7) / 8;
  localparam int unsigned ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam logic [8:0]  CAP       = 9'(CAP_BITS);
  localparam logic [5:0]  DEPTH6    = 6'(MAP_DEPTH);

  logic [8:0]        bits_in_use;
  logic [1:0]        act_q;
  logic [7:0]        idx_q;
  logic [8:0]        cnt_q;
  logic [4:0]        scan;
  logic [7:0]        mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] vld;
  logic [7:0]        rdata;
  logic              rvld;
  logic [7:0]        rbyte;
  logic [4:0]        raddr_full;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [7:0]        wdata;
  logic              in_range;
  logic [7:0]        zmask;
  logic              zhit;
  logic [2:0]        zpos;
  logic              last_byte;
  logic              is_find;
  logic              res_set;
  logic              res_found;
  logic [7:0]        res_index;
  logic [7:0]        onehot;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= CNT_RESET;
    end else if (cfg_wr_en) begin
      bits_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q <= action;
      idx_q <= bit_index;
      cnt_q <= (bits_in_use > CAP) ? CAP : bits_in_use;
      scan  <= (action == ACT_FIND) ? 5'd0 : bit_index[7:3];
    end else if (cmd.eval && !status.scan_done) begin
      scan <= scan + 5'd1;
    end
  end

  assign is_find  = (act_q == ACT_FIND);
  assign in_range = ({1'b0, idx_q} < cnt_q);
  assign rbyte    = rvld ? rdata : 8'h00;
  assign onehot   = 8'h01 << idx_q[2:0];

  always_comb begin
    zmask = 8'h00;
    for (int p = 0; p < 8; p++) begin
      zmask[p] = ~rbyte[p] & ({1'b0, scan, 3'(p)} < cnt_q);
    end
    zhit = |zmask;
    zpos = 3'd0;
    for (int p = 7; p >= 0; p--) begin
      if (zmask[p]) begin
        zpos = 3'(p);
      end
    end
  end

  assign last_byte        = ({1'b0, scan, 3'b111} + 9'd1) >= cnt_q;
  assign status.scan_done = !is_find || zhit || last_byte;
  assign status.out_free  = !out_valid || out_ready;

  assign raddr_full = (cmd.eval && !status.scan_done) ? scan + 5'd1 : scan;
  assign raddr      = ({1'b0, raddr_full} < DEPTH6) ? raddr_full[ADDR_W-1:0] : '0;

  assign we    = cmd.eval && in_range && (act_q == ACT_SET || act_q == ACT_CLEAR);
  assign wdata = (act_q == ACT_SET) ? (rbyte | onehot) : (rbyte & ~onehot);

  // map storage; entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (we) begin
      mem[scan[ADDR_W-1:0]] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (we) begin
        vld[scan[ADDR_W-1:0]] <= 1'b1;
      end
      rvld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && status.scan_done) begin
      res_set   <= (act_q == ACT_TEST) && in_range && rbyte[idx_q[2:0]];
      res_found <= is_find && zhit;
      res_index <= (is_find && zhit) ? {scan, zpos} : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bit_was_set <= res_set;
      found       <= res_found;
      free_index  <= res_index;
    end
  end

  // MAP_BYTES bounds the storage that the index span can reach
  if (MAP_DEPTH > MAP_BYTES) begin : g_depth_check
    $error("map depth exceeds map size");
  end

endmodule

[rtl/bitmap_allocator.sv]
// Bitmap allocator: a map of usage flags, one per resource, with four actions.
// Input channel (in_valid/in_ready) carries action and bit_index: set, clear,
// test, or find-first-zero. Every item gives exactly one result on the output
// channel (out_valid/out_ready): bit_was_set for test, found and free_index
// for find; fields that do not apply are zero.
// bits_in_use (cfg_wr_en/cfg_wr_data) limits the map; indices at or above it
// are ignored by set/clear, read as zero by test and skipped by find. Write it
// only while the block is idle.
// Flow: an item passes through the read, evaluate and output states; set,
// clear and test evaluate once, find evaluates until a zero or the last
// byte in range turns up. The map is one byte-wide memory with a registered
// read port, scanned one byte per cycle. One item is in work at a time; the
// next is accepted once the previous result sits in the output register.
// Reset clears all flags (per-byte valid bits, no clearing pass), sets
// bits_in_use to 256 and empties the output register.
// If the receiver stalls, the result holds in the output register and the
// block stops after finishing the next item until out_ready returns.
module bitmap_allocator #(
  parameter int unsigned MAP_BITS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] bit_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       bit_was_set,
  output logic       found,
  output logic [7:0] free_index
);
  import bma_pkg::*;

  bma_cmd_t    cmd;
  bma_status_t status;

  bma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bma_dp #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .action      (action),
    .bit_index   (bit_index),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bit_was_set (bit_was_set),
    .found       (found),
    .free_index  (free_index)
  );

endmodule

[test/bma_check.sv]
`timescale 1ns / 100ps
module bma_check #(
  parameter int unsigned MAP_BITS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  bit_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        bit_was_set,
  input  logic        found,
  input  logic [7:0]  free_index,
  output int unsigned errors,
  output int unsigned owed
);
  import bma_pkg::*;

  typedef struct packed {
    logic       was_set;
    logic       hit;
    logic [7:0] slot;
  } answer_t;

  answer_t      owed_q[$];
  logic [255:0] flag_map;
  logic [8:0]   span_cfg;
  int unsigned  result_no;

  task automatic report(input string msg);
    if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned live_span();
    int unsigned n;
    n = span_cfg;
    if (n > MAP_BITS) n = MAP_BITS;
    if (n > INDEX_SPAN) n = INDEX_SPAN;
    return n;
  endfunction

  // applies one action to the flag map and returns the answer it gives
  function automatic answer_t evaluate_action(input logic [1:0] act, input logic [7:0] idx);
    answer_t     r;
    int unsigned span;
    span = live_span();
    r = '0;
    case (act)
      ACT_SET: if (idx < span) flag_map[idx] = 1'b1;
      ACT_CLEAR: if (idx < span) flag_map[idx] = 1'b0;
      ACT_TEST: r.was_set = (idx < span) && flag_map[idx];
      default: begin
        for (int i = 0; i < span && !r.hit; i++) begin
          if (!flag_map[i]) begin
            r.hit = 1'b1;
            r.slot = 8'(i);
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      flag_map = '0;
      span_cfg = CNT_RESET;
      owed_q.delete();
      result_no = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing owed", result_no));
        end else begin
          want = owed_q.pop_front();
          if (bit_was_set !== want.was_set)
            report($sformatf("result %0d: bit_was_set %b, want %b",
                             result_no, bit_was_set, want.was_set));
          if (found !== want.hit)
            report($sformatf("result %0d: found %b, want %b", result_no, found, want.hit));
          if (free_index !== want.slot)
            report($sformatf("result %0d: free_index %0d, want %0d",
                             result_no, free_index, want.slot));
        end
        result_no++;
      end
      if (in_valid && in_ready) owed_q.push_back(evaluate_action(action, bit_index));
      if (cfg_wr_en) span_cfg = cfg_wr_data;
    end
    owed = owed_q.size();
  end

endmodule

[test/bitmap_allocator_tb.sv]
`timescale 1ns / 100ps
module bitmap_allocator_tb;
  import bma_pkg::*;

  localparam int unsigned RUN_LIMIT = 500000;
  localparam int unsigned RANDOM_ITEMS = 650;

  typedef enum int unsigned {SEG_ALLOC, SEG_MIX, SEG_FREE, SEG_PROBE} seg_t;
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_CADENCE, RX_CHOKE} rx_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [7:0]  bit_index;
  logic        out_valid;
  logic        out_ready;
  logic        bit_was_set;
  logic        found;
  logic [7:0]  free_index;
  int unsigned errors;
  int unsigned owed;

  int unsigned burst_left;
  int unsigned sent;
  logic        bursty;
  logic [8:0]  span_now;

  bitmap_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .bit_index   (bit_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bit_was_set (bit_was_set),
    .found       (found),
    .free_index  (free_index)
  );

  bma_check watch (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .bit_index   (bit_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bit_was_set (bit_was_set),
    .found       (found),
    .free_index  (free_index),
    .errors      (errors),
    .owed        (owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // the receiver picks one of four stall patterns at random and moves to a new one after each stretch
  initial begin
    rx_t         mode;
    int unsigned stretch;
    int unsigned period;
    int unsigned duty;
    out_ready = 1'b0;
    forever begin
      mode = rx_t'($urandom_range(0, 3));
      stretch = $urandom_range(20, 200);
      period = $urandom_range(2, 9);
      duty = $urandom_range(1, period - 1);
      for (int k = 0; k < stretch; k++) begin
        case (mode)
          RX_OPEN: out_ready = 1'b1;
          RX_COIN: out_ready = 1'($urandom_range(0, 1));
          RX_CADENCE: out_ready = (k % period) >= duty;
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns after acceptance (later if a burst gap follows)
  task automatic push_item(input logic [1:0] act, input logic [7:0] idx);
    in_valid = 1'b1;
    action = act;
    bit_index = idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (bursty) begin
        in_valid = 1'b0;
        action = 2'($urandom);
        bit_index = 8'($urandom);
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
    end
  endtask

  task automatic set_count(input logic [8:0] v);
    in_valid = 1'b0;
    while (owed != 0) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    span_now = (v > 9'd256) ? 9'd256 : v;
  endtask

  function automatic logic [7:0] pick_index();
    if (span_now != 0 && $urandom_range(0, 7) != 0)
      return 8'($urandom_range(0, span_now - 1));
    return 8'($urandom);
  endfunction

  task automatic random_segment();
    seg_t        kind;
    int unsigned len;
    int unsigned start;
    kind = seg_t'($urandom_range(0, 3));
    len = $urandom_range(4, 20);
    case (kind)
      SEG_ALLOC: begin
        // contiguous allocation from a base, then look for the next hole
        start = ($urandom_range(0, 1) != 0 || span_now == 0) ? 0 :
                $urandom_range(0, span_now - 1);
        len = $urandom_range(1, 40);
        for (int k = 0; k < len; k++) push_item(ACT_SET, 8'(start + k));
        push_item(ACT_FIND, 8'($urandom));
      end
      SEG_MIX: begin
        for (int k = 0; k < len; k++) push_item(2'($urandom), pick_index());
      end
      SEG_FREE: begin
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 2))
            0: push_item(ACT_CLEAR, pick_index());
            1: push_item(ACT_TEST, pick_index());
            default: push_item(ACT_FIND, 8'($urandom));
          endcase
        end
      end
      default: begin
        for (int k = 0; k < len; k++)
          push_item(($urandom_range(0, 1) != 0) ? ACT_FIND : ACT_TEST, pick_index());
      end
    endcase
  endtask

  task automatic run_phase(input logic [8:0] v);
    int unsigned phase_end;
    set_count(v);
    bursty = ($urandom_range(0, 3) != 0);
    phase_end = sent + $urandom_range(30, 60);
    while (sent < phase_end) random_segment();
  endtask

  initial begin
    logic [8:0] fixed_counts[11];
    int unsigned target;
    fixed_counts = '{9'd0, 9'd8, 9'd511, 9'd1, 9'd37, 9'd300, 9'd255, 9'd4,
                     9'd256, 9'd100, 9'd257};
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    action = ACT_SET;
    bit_index = '0;
    burst_left = 1;
    bursty = 1'b1;
    sent = 0;
    span_now = 9'd256;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // reset count: empty map, edges, a full first byte
    push_item(ACT_FIND, 8'd0);
    push_item(ACT_TEST, 8'd0);
    push_item(ACT_TEST, 8'd255);
    push_item(ACT_SET, 8'd0);
    push_item(ACT_SET, 8'd255);
    push_item(ACT_TEST, 8'd255);
    push_item(ACT_FIND, 8'd0);
    for (int b = 1; b < 8; b++) push_item(ACT_SET, 8'(b));
    push_item(ACT_FIND, 8'd0);
    push_item(ACT_CLEAR, 8'd0);
    push_item(ACT_FIND, 8'd255);
    push_item(ACT_SET, 8'd0);
    // shrunk count hides flags and ignores out-of-range writes
    set_count(9'd4);
    push_item(ACT_TEST, 8'd7);
    push_item(ACT_FIND, 8'd0);
    push_item(ACT_SET, 8'd200);
    push_item(ACT_CLEAR, 8'd2);
    set_count(9'd0);
    push_item(ACT_FIND, 8'd0);
    push_item(ACT_SET, 8'd5);
    set_count(9'd511);
    push_item(ACT_TEST, 8'd7);
    push_item(ACT_TEST, 8'd200);
    push_item(ACT_FIND, 8'd0);

    target = sent + RANDOM_ITEMS;
    foreach (fixed_counts[i]) run_phase(fixed_counts[i]);
    while (sent < target)
      run_phase(($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) :
                9'($urandom_range(0, 256)));

    in_valid = 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
